[src/ppb_pkg.sv]
// Package with constants and codes for the pending packet buffer.
`timescale 1ns / 1ps
`default_nettype none
package ppb_pkg;
  localparam int SLOTS = 64;
  localparam int TAG_BITS = 16;
  localparam int IDX_BITS = $clog2(SLOTS);
  localparam int CNT_BITS = 7;

  localparam logic [2:0] KIND_ENQ = 3'd0;
  localparam logic [2:0] KIND_QUERY = 3'd1;
  localparam logic [2:0] KIND_RELEASE = 3'd2;
  localparam logic [2:0] KIND_DISCARD = 3'd3;
  localparam logic [2:0] KIND_FLUSH = 3'd4;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_PRESENT = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [2:0] ST_DISCARDED = 3'd5;
  localparam logic [2:0] ST_FLUSHED = 3'd6;
  localparam logic [2:0] ST_NONE = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;
endpackage
`default_nettype wire

[src/pending_packet_buffer_by_dest.sv]
// Top level of the pending packet buffer keyed by destination.
//
// Channel  Direction  Handshake               Fields
// in_      input      start high, busy low    in_kind, in_dest_addr, in_packet_tag
// out_     output     out_valid for one cycle out_status, out_tag, out_dest,
//                                             out_removed_count, out_last
// cfg_     input      cfg_we                  cfg_data (max_entries)
//
// Enqueue, flush and unknown kinds give their beat in the cycle after start.
// Query, release and discard scan the store one slot per cycle through one
// memory read port and compare unit, busy through the read, scan and done states.
// Reset empties the store at once; slot contents are not cleared.
// The receiver cannot stall; each beat shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module pending_packet_buffer_by_dest (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_kind,
  input  wire logic [31:0]                   in_dest_addr,
  input  wire logic [ppb_pkg::TAG_BITS-1:0]  in_packet_tag,
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic [ppb_pkg::TAG_BITS-1:0]       out_tag,
  output logic [31:0]                        out_dest,
  output logic [6:0]                         out_removed_count,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [6:0]                    cfg_data
);
  localparam int IB = ppb_pkg::IDX_BITS;
  localparam int CB = ppb_pkg::CNT_BITS;
  localparam int TB = ppb_pkg::TAG_BITS;

  logic [31:0] mem_dest [ppb_pkg::SLOTS];
  logic [TB-1:0] mem_tag [ppb_pkg::SLOTS];

  ppb_pkg::state_t state_r, state_nxt;
  logic [6:0] max_r;
  logic [CB-1:0] count_r, count_nxt;
  logic [CB-1:0] rd_r, rd_nxt;
  logic [CB-1:0] keep_r, keep_nxt;
  logic [CB-1:0] n_r, n_nxt;
  logic [2:0] kind_r;
  logic [31:0] key_r;
  logic hit_r, hit_nxt;
  logic [31:0] rdest_r;
  logic [TB-1:0] rtag_r;
  logic rv_r;

  logic we;
  logic [IB-1:0] waddr;
  logic [31:0] wdest;
  logic [TB-1:0] wtag;
  logic match;
  logic [CB-1:0] limit;
  logic ov_nxt, ol_nxt;
  logic [2:0] os_nxt;
  logic [TB-1:0] ot_nxt;
  logic [31:0] od_nxt;
  logic [6:0] oc_nxt;

  assign limit = (max_r > 7'(ppb_pkg::SLOTS)) ? CB'(ppb_pkg::SLOTS) : max_r;
  assign match = rv_r && (rdest_r == key_r);
  assign busy = (state_r != ppb_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem_dest[waddr] <= wdest;
      mem_tag[waddr] <= wtag;
    end
    rdest_r <= mem_dest[rd_r[IB-1:0]];
    rtag_r <= mem_tag[rd_r[IB-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rd_nxt = rd_r;
    keep_nxt = keep_r;
    n_nxt = n_r;
    hit_nxt = hit_r;
    we = 1'b0;
    waddr = keep_r[IB-1:0];
    wdest = rdest_r;
    wtag = rtag_r;
    ov_nxt = 1'b0;
    os_nxt = ppb_pkg::ST_NONE;
    ot_nxt = '0;
    od_nxt = '0;
    oc_nxt = '0;
    ol_nxt = 1'b0;
    unique case (state_r)
      ppb_pkg::S_IDLE: begin
        if (start) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          unique case (in_kind)
            ppb_pkg::KIND_ENQ: begin
              ot_nxt = in_packet_tag;
              od_nxt = in_dest_addr;
              if (count_r >= limit) begin
                os_nxt = ppb_pkg::ST_FULL;
              end else begin
                os_nxt = ppb_pkg::ST_ACCEPTED;
                we = 1'b1;
                waddr = count_r[IB-1:0];
                wdest = in_dest_addr;
                wtag = in_packet_tag;
                count_nxt = count_r + 1'b1;
              end
            end
            ppb_pkg::KIND_FLUSH: begin
              os_nxt = ppb_pkg::ST_FLUSHED;
              oc_nxt = count_r;
              count_nxt = '0;
            end
            ppb_pkg::KIND_QUERY, ppb_pkg::KIND_RELEASE, ppb_pkg::KIND_DISCARD: begin
              ov_nxt = 1'b0;
              ol_nxt = 1'b0;
              rd_nxt = '0;
              keep_nxt = '0;
              n_nxt = '0;
              hit_nxt = 1'b0;
              state_nxt = ppb_pkg::S_READ;
            end
            default: os_nxt = ppb_pkg::ST_NONE;
          endcase
        end
      end
      ppb_pkg::S_READ: begin
        rd_nxt = rd_r + 1'b1;
        state_nxt = ppb_pkg::S_SCAN;
      end
      ppb_pkg::S_SCAN: begin
        if (rv_r) begin
          if (match) begin
            hit_nxt = 1'b1;
            if (kind_r != ppb_pkg::KIND_QUERY) begin
              n_nxt = n_r + 1'b1;
              ov_nxt = 1'b1;
              os_nxt = (kind_r == ppb_pkg::KIND_RELEASE) ? ppb_pkg::ST_RELEASED
                                                           : ppb_pkg::ST_DISCARDED;
              ot_nxt = rtag_r;
              od_nxt = rdest_r;
              oc_nxt = n_r + 1'b1;
            end
          end else begin
            if (kind_r != ppb_pkg::KIND_QUERY) begin
              we = 1'b1;
              waddr = keep_r[IB-1:0];
            end
            keep_nxt = keep_r + 1'b1;
          end
          rd_nxt = rd_r + 1'b1;
        end else begin
          state_nxt = ppb_pkg::S_DONE;
        end
      end
      ppb_pkg::S_DONE: begin
        state_nxt = ppb_pkg::S_IDLE;
        if (kind_r == ppb_pkg::KIND_QUERY) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          os_nxt = hit_r ? ppb_pkg::ST_PRESENT : ppb_pkg::ST_ABSENT;
        end else begin
          count_nxt = keep_r;
          if (n_r == '0) begin
            ov_nxt = 1'b1;
            ol_nxt = 1'b1;
            os_nxt = ppb_pkg::ST_NONE;
          end
        end
      end
      default: state_nxt = ppb_pkg::S_IDLE;
    endcase
  end

  // Each removal beat is held back one beat so that the last one's last flag is known.
  logic hold_v_r;
  logic [2:0] hold_s_r;
  logic [TB-1:0] hold_t_r;
  logic [31:0] hold_d_r;
  logic [6:0] hold_c_r;
  logic scan_beat;
  assign scan_beat = (state_r == ppb_pkg::S_SCAN) && ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppb_pkg::S_IDLE;
      max_r <= 7'd64;
      count_r <= '0;
      out_valid <= 1'b0;
      hold_v_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) max_r <= cfg_data;
      count_r <= count_nxt;
      rv_r <= (state_nxt == ppb_pkg::S_SCAN) && (rd_nxt <= count_r) &&
              !((state_r == ppb_pkg::S_SCAN) && !rv_r);
      if (scan_beat) begin
        hold_v_r <= 1'b1;
        out_valid <= hold_v_r;
      end else if (state_r == ppb_pkg::S_DONE && hold_v_r) begin
        hold_v_r <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        out_valid <= ov_nxt;
      end
    end
    rd_r <= rd_nxt;
    keep_r <= keep_nxt;
    n_r <= n_nxt;
    hit_r <= hit_nxt;
    if (start && !busy) begin
      kind_r <= in_kind;
      key_r <= in_dest_addr;
    end
    if (scan_beat) begin
      hold_s_r <= os_nxt;
      hold_t_r <= ot_nxt;
      hold_d_r <= od_nxt;
      hold_c_r <= oc_nxt;
      out_status <= hold_s_r;
      out_tag <= hold_t_r;
      out_dest <= hold_d_r;
      out_removed_count <= hold_c_r;
      out_last <= 1'b0;
    end else if (state_r == ppb_pkg::S_DONE && hold_v_r) begin
      out_status <= hold_s_r;
      out_tag <= hold_t_r;
      out_dest <= hold_d_r;
      out_removed_count <= hold_c_r;
      out_last <= 1'b1;
    end else begin
      out_status <= os_nxt;
      out_tag <= ot_nxt;
      out_dest <= od_nxt;
      out_removed_count <= oc_nxt;
      out_last <= ol_nxt;
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CB'(ppb_pkg::SLOTS)) else $error("entry count above capacity");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppb_pkg::S_IDLE) |-> !hold_v_r) else $error("held beat while idle");
  a_keep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppb_pkg::S_SCAN) |-> (keep_r <= count_r)) else $error("keep index overran");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy || $past(start)) else $error("busy after last beat");
endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the pending packet buffer keyed by destination.
`timescale 1ns / 1ps
module testbench;
  localparam int TB = ppb_pkg::TAG_BITS;

  typedef struct packed {
    logic [2:0]    status;
    logic [TB-1:0] tag;
    logic [31:0]   dest;
    logic [6:0]    count;
    logic          last;
  } beat_t;

  typedef struct {
    logic [2:0]    kind;
    logic [31:0]   dest;
    logic [TB-1:0] tag;
    bit            typed;
    beat_t         want;
  } row_t;

  localparam int CYCLE_LIMIT = 400000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [2:0]          in_kind;
  logic [31:0]         in_dest_addr;
  logic [TB-1:0]       in_packet_tag;
  logic                out_valid;
  logic [2:0]          out_status;
  logic [TB-1:0]       out_tag;
  logic [31:0]         out_dest;
  logic [6:0]          out_removed_count;
  logic                out_last;
  logic                cfg_we;
  logic [6:0]          cfg_data;

  pending_packet_buffer_by_dest dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_dest_addr(in_dest_addr), .in_packet_tag(in_packet_tag),
    .out_valid(out_valid), .out_status(out_status), .out_tag(out_tag),
    .out_dest(out_dest), .out_removed_count(out_removed_count), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  logic [31:0]         held_dest [ppb_pkg::SLOTS];
  logic [TB-1:0]       held_tag [ppb_pkg::SLOTS];
  int                  held_count;
  int                  limit_reg;
  beat_t               pending_beats[$];
  row_t                rows[$];
  int                  errors;
  int                  items_sent;
  int                  beats_seen;
  int                  cycles;
  bit                  idling_on;
  logic [31:0]         dest_pool [4];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pending_packet_buffer_by_dest verification failed");
      $finish;
    end
  end

  function automatic beat_t mk(logic [2:0] s, logic [TB-1:0] t, logic [31:0] d,
                               int c, logic l);
    beat_t b;
    b.status = s;
    b.tag = t;
    b.dest = d;
    b.count = c[6:0];
    b.last = l;
    return b;
  endfunction

  task automatic predict_beats(logic [2:0] kind, logic [31:0] dest, logic [TB-1:0] tag);
    int cap;
    int keep;
    int n;
    cap = (limit_reg < ppb_pkg::SLOTS) ? limit_reg : ppb_pkg::SLOTS;
    case (kind)
      ppb_pkg::KIND_ENQ: begin
        if (held_count >= cap) begin
          pending_beats.push_back(mk(ppb_pkg::ST_FULL, tag, dest, 0, 1'b1));
        end else begin
          held_dest[held_count] = dest;
          held_tag[held_count] = tag;
          held_count++;
          pending_beats.push_back(mk(ppb_pkg::ST_ACCEPTED, tag, dest, 0, 1'b1));
        end
      end
      ppb_pkg::KIND_QUERY: begin
        n = 0;
        for (int i = 0; i < held_count; i++) if (held_dest[i] == dest) n++;
        pending_beats.push_back(mk((n > 0) ? ppb_pkg::ST_PRESENT : ppb_pkg::ST_ABSENT,
                                   '0, '0, 0, 1'b1));
      end
      ppb_pkg::KIND_RELEASE, ppb_pkg::KIND_DISCARD: begin
        keep = 0;
        n = 0;
        for (int i = 0; i < held_count; i++) begin
          if (held_dest[i] == dest) begin
            n++;
            pending_beats.push_back(mk((kind == ppb_pkg::KIND_RELEASE) ?
                                       ppb_pkg::ST_RELEASED : ppb_pkg::ST_DISCARDED,
                                       held_tag[i], held_dest[i], n, 1'b0));
          end else begin
            held_dest[keep] = held_dest[i];
            held_tag[keep] = held_tag[i];
            keep++;
          end
        end
        held_count = keep;
        if (n == 0) pending_beats.push_back(mk(ppb_pkg::ST_NONE, '0, '0, 0, 1'b1));
        else pending_beats[$].last = 1'b1;
      end
      ppb_pkg::KIND_FLUSH: begin
        pending_beats.push_back(mk(ppb_pkg::ST_FLUSHED, '0, '0, held_count, 1'b1));
        held_count = 0;
      end
      default: pending_beats.push_back(mk(ppb_pkg::ST_NONE, '0, '0, 0, 1'b1));
    endcase
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst_n && out_valid) begin
      got = mk(out_status, out_tag, out_dest, int'(out_removed_count), out_last);
      beats_seen++;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat status=%0d tag=%h dest=%h count=%0d last=%b",
                 $time, got.status, got.tag, got.dest, got.count, got.last);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected status=%0d tag=%h dest=%h count=%0d last=%b",
                   $time, want.status, want.tag, want.dest, want.count, want.last);
          $display("%0t:          actual   status=%0d tag=%h dest=%h count=%0d last=%b",
                   $time, got.status, got.tag, got.dest, got.count, got.last);
        end
      end
    end
  end

  task automatic send(logic [2:0] kind, logic [31:0] dest, logic [TB-1:0] tag,
                      bit typed, beat_t want);
    start <= 1'b1;
    in_kind <= kind;
    in_dest_addr <= dest;
    in_packet_tag <= tag;
    do @(posedge clk); while (busy);
    predict_beats(kind, dest, tag);
    if (typed) begin
      void'(pending_beats.pop_back());
      pending_beats.push_back(want);
    end
    items_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain_all();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] value);
    drain_all();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = int'(value);
  endtask

  task automatic add_row(logic [2:0] k, logic [31:0] d, logic [TB-1:0] t, bit typed,
                         beat_t want);
    row_t r;
    r.kind = k;
    r.dest = d;
    r.tag = t;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  initial begin
    logic [6:0]  phase_limit [10];
    int          pick;
    logic [2:0]  k;
    logic [31:0] d;
    beat_t       none_beat;
    errors = 0;
    items_sent = 0;
    beats_seen = 0;
    cycles = 0;
    idling_on = 1'b1;
    held_count = 0;
    limit_reg = 64;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = '0;
    in_dest_addr = '0;
    in_packet_tag = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    none_beat = mk(ppb_pkg::ST_NONE, '0, '0, 0, 1'b1);
    add_row(ppb_pkg::KIND_QUERY, 32'h0, '0, 1, mk(ppb_pkg::ST_ABSENT, '0, '0, 0, 1'b1));
    add_row(ppb_pkg::KIND_RELEASE, 32'h0, '0, 1, none_beat);
    add_row(ppb_pkg::KIND_DISCARD, 32'hFFFFFFFF, '0, 1, none_beat);
    add_row(ppb_pkg::KIND_FLUSH, 32'h0, '0, 1, mk(ppb_pkg::ST_FLUSHED, '0, '0, 0, 1'b1));
    add_row(3'd5, 32'h0A000001, 16'h1111, 1, none_beat);
    add_row(3'd6, 32'h0A000001, 16'h2222, 1, none_beat);
    add_row(3'd7, 32'hFFFFFFFF, 16'hFFFF, 1, none_beat);
    add_row(ppb_pkg::KIND_ENQ, 32'h0, 16'h0, 1,
            mk(ppb_pkg::ST_ACCEPTED, 16'h0, 32'h0, 0, 1'b1));
    add_row(ppb_pkg::KIND_ENQ, 32'hFFFFFFFF, 16'hFFFF, 1,
            mk(ppb_pkg::ST_ACCEPTED, 16'hFFFF, 32'hFFFFFFFF, 0, 1'b1));
    add_row(ppb_pkg::KIND_ENQ, 32'h0, 16'h1234, 0, none_beat);
    add_row(ppb_pkg::KIND_ENQ, 32'hC0A80001, 16'hAAAA, 0, none_beat);
    add_row(ppb_pkg::KIND_QUERY, 32'h0, '0, 0, none_beat);
    add_row(ppb_pkg::KIND_QUERY, 32'hFFFFFFFF, '0, 0, none_beat);
    add_row(ppb_pkg::KIND_QUERY, 32'h55555555, '0, 0, none_beat);
    add_row(ppb_pkg::KIND_RELEASE, 32'h0, '0, 0, none_beat);
    add_row(ppb_pkg::KIND_DISCARD, 32'hFFFFFFFF, '0, 0, none_beat);
    add_row(ppb_pkg::KIND_ENQ, 32'hC0A80001, 16'h5555, 0, none_beat);
    add_row(ppb_pkg::KIND_ENQ, 32'hAAAAAAAA, 16'h8001, 0, none_beat);
    add_row(ppb_pkg::KIND_RELEASE, 32'h12345678, '0, 0, none_beat);
    add_row(ppb_pkg::KIND_FLUSH, 32'h0, '0, 0, none_beat);
    add_row(ppb_pkg::KIND_ENQ, 32'h01020304, 16'h7FFE, 0, none_beat);
    add_row(ppb_pkg::KIND_DISCARD, 32'h01020304, '0, 0, none_beat);
    foreach (rows[i]) send(rows[i].kind, rows[i].dest, rows[i].tag, rows[i].typed, rows[i].want);

    phase_limit = '{7'd64, 7'd0, 7'd1, 7'd127, 7'd2, 7'd5, 7'd63, 7'd64, 7'd100, 7'd127};
    phase_limit[5] = 7'($urandom_range(1, 64));
    phase_limit[8] = 7'($urandom_range(0, 127));
    for (int p = 0; p < 10; p++) begin
      write_limit(phase_limit[p]);
      foreach (dest_pool[j]) dest_pool[j] = $urandom;
      idling_on = (p != 9);
      for (int n = 0; n < 45; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) k = ppb_pkg::KIND_ENQ;
        else if (pick < 65) k = ppb_pkg::KIND_QUERY;
        else if (pick < 78) k = ppb_pkg::KIND_RELEASE;
        else if (pick < 91) k = ppb_pkg::KIND_DISCARD;
        else if (pick < 96) k = ppb_pkg::KIND_FLUSH;
        else k = 3'($urandom_range(5, 7));
        d = ($urandom_range(0, 99) < 85) ? dest_pool[$urandom_range(0, 3)] : $urandom;
        send(k, d, TB'($urandom), 0, none_beat);
        if (p == 2) drain_all();
      end
    end

    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Ran %0d commands and checked %0d result beats over ten limit settings,",
             items_sent, beats_seen);
    $display("including limits of zero, one and above capacity.");
    if (errors == 0) begin
      $display("pending_packet_buffer_by_dest verification clean");
    end else begin
      $display("pending_packet_buffer_by_dest verification failed");
    end
    $finish;
  end
endmodule

[sim.f]
src/ppb_pkg.sv
src/pending_packet_buffer_by_dest.sv
test/testbench.sv
